// ----- hw/rtl/pps_pkg.sv -----
package pps_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int TIME_W         = 21;
  localparam int SLOT_FIELD_W   = 4;
  localparam int IN_TDATA_W     = 48;
  localparam int OUT_TDATA_W    = 96;

  // request kind carried on in_tuser
  typedef enum logic {REQ_LOAD = 1'b0, REQ_TICK = 1'b1} req_t;

  // one task table entry
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } entry_t;

  // in_tdata layout, lowest bits last
  typedef struct packed {
    logic [3:0]              pad;
    logic [7:0]              prio_level;
    logic [15:0]             burst_length;
    logic [15:0]             arrival_time;
    logic [SLOT_FIELD_W-1:0] slot;
  } in_data_t;

  // out_tdata layout, lowest bits last
  typedef struct packed {
    logic [3:0]              pad;
    logic                    all_done;
    logic [TIME_W-1:0]       waiting_time;
    logic [TIME_W-1:0]       turnaround;
    logic [TIME_W-1:0]       finish_time;
    logic                    completed;
    logic                    new_segment;
    logic [TIME_W-1:0]       tick_time;
    logic [SLOT_FIELD_W-1:0] run_slot;
    logic                    dispatched;
  } result_t;

endpackage

// ----- hw/rtl/pps_table.sv -----
module pps_table #(
  parameter int TASK_SLOTS = pps_pkg::TASK_SLOTS_DEF,
  localparam int SLOT_W = $clog2(TASK_SLOTS),
  localparam int CNT_W = $clog2(TASK_SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   wr_addr,
  input  pps_pkg::entry_t     wr_data,
  input  logic                rd_en,
  input  logic [SLOT_W-1:0]   rd_addr,
  output pps_pkg::entry_t     rd_data,
  output logic                rd_act,
  output logic                idle
);

  pps_pkg::entry_t mem_r [TASK_SLOTS];
  pps_pkg::entry_t rd_data_r;
  logic [TASK_SLOTS-1:0] act_r;
  logic                  rd_act_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  new_nz;

  // act_r marks slots with work left; entries without it read as zero work
  assign new_nz = (wr_data.remaining != 16'd0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= '0;
      rd_act_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (rd_en) begin
        rd_act_r <= act_r[rd_addr];
      end
      if (wr_en) begin
        act_r[wr_addr] <= new_nz;
        cnt_r <= cnt_r - CNT_W'(act_r[wr_addr]) + CNT_W'(new_nz);
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_act  = rd_act_r;
  assign idle    = (cnt_r == '0);

endmodule

// ----- hw/rtl/pps_ctrl.sv -----
module pps_ctrl #(
  parameter int TASK_SLOTS = pps_pkg::TASK_SLOTS_DEF,
  localparam int SLOT_W = $clog2(TASK_SLOTS),
  localparam int CNT_W = $clog2(TASK_SLOTS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  pps_pkg::in_data_t                 in_data,
  output logic                              tbl_wr_en,
  output logic [SLOT_W-1:0]                 tbl_wr_addr,
  output pps_pkg::entry_t                   tbl_wr_data,
  output logic                              tbl_rd_en,
  output logic [SLOT_W-1:0]                 tbl_rd_addr,
  input  pps_pkg::entry_t                   tbl_rd_data,
  input  logic                              tbl_rd_act,
  input  logic                              tbl_idle,
  input  logic                              out_free,
  output logic                              res_valid,
  output pps_pkg::result_t                  res_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD, ST_FIN} state_t;

  state_t                        state_r;
  logic [pps_pkg::TIME_W-1:0]    time_r;
  logic [pps_pkg::TIME_W-1:0]    nowp1_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          pend_r;
  logic [SLOT_W-1:0]             pend_idx_r;
  logic                          found_r;
  logic [SLOT_W-1:0]             best_idx_r;
  pps_pkg::entry_t               best_r;
  logic [SLOT_W-1:0]             last_slot_r;
  logic                          last_valid_r;
  pps_pkg::result_t              res_r;

  logic accept;
  logic slot_ok;
  logic eligible;
  logic better;
  pps_pkg::entry_t upd_entry;
  pps_pkg::result_t upd_res;
  logic [pps_pkg::TIME_W-1:0] tat;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign slot_ok  = (9'(in_data.slot) < 9'(TASK_SLOTS));

  always_comb begin
    upd_entry           = best_r;
    upd_entry.remaining = best_r.remaining - 16'd1;
  end

  assign tbl_wr_en   = (accept && (in_req_type == pps_pkg::REQ_LOAD) && slot_ok) ||
                       (state_r == ST_UPD && found_r);
  assign tbl_wr_addr = (state_r == ST_UPD) ? best_idx_r : SLOT_W'(in_data.slot);
  assign tbl_wr_data = (state_r == ST_UPD) ? upd_entry :
                       {in_data.arrival_time, in_data.burst_length,
                        in_data.prio_level, in_data.burst_length};

  assign tbl_rd_en   = (state_r == ST_SCAN) && (cnt_r < CNT_W'(TASK_SLOTS));
  assign tbl_rd_addr = cnt_r[SLOT_W-1:0];

  // slots arrive in ascending order, so a tie on prio and arrival keeps the lower slot
  assign eligible = tbl_rd_act && (pps_pkg::TIME_W'(tbl_rd_data.arrival) <= time_r);
  assign better   = eligible && (!found_r || (tbl_rd_data.prio < best_r.prio) ||
                    ((tbl_rd_data.prio == best_r.prio) &&
                     (tbl_rd_data.arrival < best_r.arrival)));

  // tick result; time_r still holds the time of this tick
  always_comb begin
    tat               = nowp1_r - pps_pkg::TIME_W'(best_r.arrival);
    upd_res           = '0;
    upd_res.tick_time = time_r;
    if (found_r) begin
      upd_res.dispatched  = 1'b1;
      upd_res.run_slot    = pps_pkg::SLOT_FIELD_W'(best_idx_r);
      upd_res.new_segment = !last_valid_r || (last_slot_r != best_idx_r);
      if (best_r.remaining == 16'd1) begin
        upd_res.completed    = 1'b1;
        upd_res.finish_time  = nowp1_r;
        upd_res.turnaround   = tat;
        upd_res.waiting_time = tat - pps_pkg::TIME_W'(best_r.burst);
      end
    end
  end

  always_comb begin
    res_data          = res_r;
    res_data.all_done = tbl_idle;
  end
  assign res_valid = (state_r == ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      time_r       <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      last_slot_r  <= '0;
      last_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            res_r <= '0;
            if (in_req_type == pps_pkg::REQ_TICK) begin
              nowp1_r <= time_r + pps_pkg::TIME_W'(1);
              cnt_r   <= '0;
              pend_r  <= 1'b0;
              found_r <= 1'b0;
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_SCAN: begin
          pend_r     <= tbl_rd_en;
          pend_idx_r <= cnt_r[SLOT_W-1:0];
          if (tbl_rd_en) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            state_r <= ST_UPD;
          end
          if (pend_r && better) begin
            found_r    <= 1'b1;
            best_idx_r <= pend_idx_r;
            best_r     <= tbl_rd_data;
          end
        end
        ST_UPD: begin
          time_r <= nowp1_r;
          res_r  <= upd_res;
          if (found_r) begin
            last_valid_r <= 1'b1;
            last_slot_r  <= best_idx_r;
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_time_holds_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> (time_r == $past(time_r)))
    else $error("time moved during scan");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr_en |-> !tbl_rd_en)
    else $error("table write during scan read");

  a_best_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && found_r) |-> (best_r.remaining != 16'd0))
    else $error("dispatched task without work");

  a_completion_dispatched: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_data.completed) |-> (res_data.dispatched && !res_data.all_done ||
                                           res_data.dispatched))
    else $error("completion without dispatch");
`endif

endmodule

// ----- hw/rtl/preemptive_priority_scheduler.sv -----
// Load transaction: the table write (for a valid slot) on acceptance, then the result state and the output register;
// tick transaction: a scan of all slots via the registered table reads, then update and result.
// One transaction in flight; a waiting result does not block the next input.
// A new input is accepted only in idle, after the result state; out_tready stalls hold that state.
// rst_n (synchronous, active low) clears time, last dispatch and all slot work.
module preemptive_priority_scheduler #(
  parameter int TASK_SLOTS = pps_pkg::TASK_SLOTS_DEF,
  localparam int SLOT_W = $clog2(TASK_SLOTS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slot, arrival_time, burst_length, prio_level
  input  logic [pps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // dispatched, run_slot, tick_time, new_segment, completed, finish_time,
  // turnaround, waiting_time, all_done
  output logic [pps_pkg::OUT_TDATA_W-1:0] out_tdata
);

  pps_pkg::in_data_t in_d;
  pps_pkg::entry_t   wr_data;
  pps_pkg::entry_t   rd_data;
  pps_pkg::result_t  res_data;
  pps_pkg::result_t  out_data_r;
  logic              out_tvalid_r;
  logic              wr_en;
  logic              rd_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [SLOT_W-1:0] rd_addr;
  logic              rd_act;
  logic              tbl_idle;
  logic              res_valid;
  logic              out_free;

  assign in_d     = in_tdata;
  assign out_free = !out_tvalid_r || out_tready;

  pps_table #(.TASK_SLOTS(TASK_SLOTS)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_act  (rd_act),
    .idle    (tbl_idle)
  );

  pps_ctrl #(.TASK_SLOTS(TASK_SLOTS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_req_type (in_tuser),
    .in_data     (in_d),
    .tbl_wr_en   (wr_en),
    .tbl_wr_addr (wr_addr),
    .tbl_wr_data (wr_data),
    .tbl_rd_en   (rd_en),
    .tbl_rd_addr (rd_addr),
    .tbl_rd_data (rd_data),
    .tbl_rd_act  (rd_act),
    .tbl_idle    (tbl_idle),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule
